// ----- src/rsc_pkg.sv -----
package rsc_pkg;

    // port widths fixed by the interface
    localparam int IN_W     = 16;
    localparam int SLOPE_W  = 48;
    localparam int CORR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int PC_W     = 13;

    // saturation limit of the reported pair count
    localparam int PC_MAX = 8191;

    // fraction bits of the slope, and of the squared coefficient
    localparam int SLOPE_FRAC = 16;
    localparam int CORR_SHIFT = 30;

    // coefficient magnitude limit and bits of its root search
    localparam int CORR_MAX  = 32767;
    localparam int ROOT_BITS = 15;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_X_CONST  = 2'd1,
        STATUS_Y_CONST  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

endpackage

// ----- src/rsc_front.sv -----
module rsc_front #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 13,
    parameter int SXW         = 29,
    parameter int SPW         = 45,
    parameter int DW          = 1 + 13 + 2 * 29 + 3 * 45
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic signed [rsc_pkg::IN_W-1:0]  sample_x,
    input  logic signed [rsc_pkg::IN_W-1:0]  sample_y,
    input  logic                             last,
    output logic                             push_valid,
    output logic [DW-1:0]                    push_data,
    input  logic                             push_ready
);

    logic [CW-1:0]                count_reg, count_next, count_acc;
    logic signed [SXW-1:0]        sx_reg, sx_next, sx_acc;
    logic signed [SXW-1:0]        sy_reg, sy_next, sy_acc;
    logic signed [SPW-1:0]        sxy_reg, sxy_next, sxy_acc;
    logic signed [SPW-1:0]        sxx_reg, sxx_next, sxx_acc;
    logic signed [SPW-1:0]        syy_reg, syy_next, syy_acc;
    logic                         ovf_reg, ovf_next, ovf_acc;
    logic signed [SAMPLE_BITS-1:0]   xv, yv;
    logic signed [2*SAMPLE_BITS-1:0] pxy, pxx, pyy;
    logic                         take;
    logic                         room;

    // low sample bits taken as two's complement
    assign xv = $signed(SAMPLE_BITS'($unsigned(sample_x)));
    assign yv = $signed(SAMPLE_BITS'($unsigned(sample_y)));
    assign pxy = xv * yv;
    assign pxx = xv * xv;
    assign pyy = yv * yv;

    assign sample_ready = push_ready;
    assign take         = sample_valid & sample_ready;
    assign room         = 32'(count_reg) < 32'(MAX_SAMPLES);

    // running sums with this request folded in
    always_comb
    begin
        count_acc = count_reg;
        sx_acc    = sx_reg;
        sy_acc    = sy_reg;
        sxy_acc   = sxy_reg;
        sxx_acc   = sxx_reg;
        syy_acc   = syy_reg;
        ovf_acc   = ovf_reg;
        if (room)
        begin
            count_acc = count_reg + CW'(1);
            sx_acc    = sx_reg + SXW'(xv);
            sy_acc    = sy_reg + SXW'(yv);
            sxy_acc   = sxy_reg + SPW'(pxy);
            sxx_acc   = sxx_reg + SPW'(pxx);
            syy_acc   = syy_reg + SPW'(pyy);
        end
        else
        begin
            ovf_acc = 1'b1;
        end
    end

    // end of a set hands the totals to the queue and clears
    always_comb
    begin
        count_next = count_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sxy_next   = sxy_reg;
        sxx_next   = sxx_reg;
        syy_next   = syy_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            if (last)
            begin
                count_next = '0;
                sx_next    = '0;
                sy_next    = '0;
                sxy_next   = '0;
                sxx_next   = '0;
                syy_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_acc;
                sx_next    = sx_acc;
                sy_next    = sy_acc;
                sxy_next   = sxy_acc;
                sxx_next   = sxx_acc;
                syy_next   = syy_acc;
                ovf_next   = ovf_acc;
            end
        end
    end

    assign push_valid = take & last;
    assign push_data  = {ovf_acc, count_acc, sx_acc, sy_acc, sxy_acc, sxx_acc, syy_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxy_reg   <= sxy_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ----- src/rsc_queue.sv -----
module rsc_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push, do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/rsc_back.sv -----
module rsc_back #(
    parameter int CW  = 13,
    parameter int SXW = 29,
    parameter int SPW = 45,
    parameter int DW  = 1 + 13 + 2 * 29 + 3 * 45
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  logic [DW-1:0]                       pop_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [rsc_pkg::SLOPE_W-1:0]  slope,
    output logic signed [rsc_pkg::CORR_W-1:0]   correlation,
    output logic [rsc_pkg::STATUS_W-1:0]        status,
    output logic [rsc_pkg::PC_W-1:0]            pair_count
);

    localparam int MW  = SPW + CW + 2;
    localparam int RW  = 2 * MW + rsc_pkg::CORR_SHIFT;
    localparam int RCW = $clog2(RW + 1);
    localparam int SW  = rsc_pkg::SLOPE_W;
    localparam int KW  = rsc_pkg::CORR_W;
    localparam int RB  = rsc_pkg::ROOT_BITS;
    localparam int CS  = rsc_pkg::CORR_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } state_t;

    // multiply steps in order
    localparam logic [2:0] OP_N_SXY = 3'd0;
    localparam logic [2:0] OP_SX_SY = 3'd1;
    localparam logic [2:0] OP_N_SXX = 3'd2;
    localparam logic [2:0] OP_SX_SX = 3'd3;
    localparam logic [2:0] OP_N_SYY = 3'd4;
    localparam logic [2:0] OP_SY_SY = 3'd5;
    localparam logic [2:0] OP_DX_DY = 3'd6;
    localparam logic [2:0] OP_M_M   = 3'd7;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic                   dsel_reg, dsel_next;
    logic [CW-1:0]          n_reg, n_next;
    logic signed [SXW-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SPW-1:0]  sxy_reg, sxy_next, sxx_reg, sxx_next, syy_reg, syy_next;
    logic                   ovf_reg, ovf_next;
    logic [2*MW-1:0]        ma_reg, ma_next, macc_reg, macc_next, p_reg, p_next;
    logic [MW-1:0]          mb_reg, mb_next;
    logic                   mneg_reg, mneg_next;
    logic signed [MW-1:0]   t1_reg, t1_next, num_reg, num_next;
    logic signed [MW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic                   neg_reg, neg_next;
    logic [RW:0]            drem_reg, drem_next;
    logic [RW-1:0]          dnd_reg, dnd_next, dsor_reg, dsor_next;
    logic [RCW-1:0]         dcnt_reg, dcnt_next;
    logic [RB-1:0]          rc_reg, rc_next;
    logic [3:0]             rb_reg, rb_next;
    rsc_pkg::status_t       st_reg, st_next;
    logic [SW-1:0]          wslope_reg, wslope_next;
    logic [KW-1:0]          wcorr_reg, wcorr_next;
    logic [rsc_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                   ov_reg, ov_next;
    logic [SW-1:0]          oslope_reg, oslope_next;
    logic [KW-1:0]          ocorr_reg, ocorr_next;
    logic [rsc_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic [rsc_pkg::PC_W-1:0] opc_reg, opc_next;

    // popped set fields
    logic                   in_ovf;
    logic [CW-1:0]          in_n;
    logic signed [SXW-1:0]  in_sx, in_sy;
    logic signed [SPW-1:0]  in_sxy, in_sxx, in_syy;

    // shared datapath terms
    logic [MW-1:0]          opa, opb;
    logic                   opneg;
    logic [MW-1:0]          pl;
    logic signed [MW-1:0]   sprod;
    logic [MW-1:0]          mnum;
    logic [RW:0]            rsh;
    logic [RW-1:0]          qsat, lim;
    logic [RB-1:0]          rt;
    logic [2*RB-1:0]        rsq;
    logic                   dx_bad, dy_bad;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        mag = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    assign {in_ovf, in_n, in_sx, in_sy, in_sxy, in_sxx, in_syy} = pop_data;

    assign pop_ready    = state_reg == ST_IDLE;
    assign result_valid = ov_reg;
    assign slope        = oslope_reg;
    assign correlation  = ocorr_reg;
    assign status       = ost_reg;
    assign pair_count   = opc_reg;

    // operand selection per multiply step
    always_comb
    begin
        opa   = '0;
        opb   = '0;
        opneg = 1'b0;
        case (op_reg)
            OP_N_SXY:
            begin
                opa   = mag(MW'(sxy_reg));
                opb   = MW'(n_reg);
                opneg = sxy_reg[SPW-1];
            end
            OP_SX_SY:
            begin
                opa   = mag(MW'(sx_reg));
                opb   = mag(MW'(sy_reg));
                opneg = sx_reg[SXW-1] ^ sy_reg[SXW-1];
            end
            OP_N_SXX:
            begin
                opa   = mag(MW'(sxx_reg));
                opb   = MW'(n_reg);
                opneg = sxx_reg[SPW-1];
            end
            OP_SX_SX:
            begin
                opa = mag(MW'(sx_reg));
                opb = mag(MW'(sx_reg));
            end
            OP_N_SYY:
            begin
                opa   = mag(MW'(syy_reg));
                opb   = MW'(n_reg);
                opneg = syy_reg[SPW-1];
            end
            OP_SY_SY:
            begin
                opa = mag(MW'(sy_reg));
                opb = mag(MW'(sy_reg));
            end
            OP_DX_DY:
            begin
                opa = dx_reg;
                opb = dy_reg;
            end
            OP_M_M:
            begin
                opa = mag(num_reg);
                opb = mag(num_reg);
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    // signed product, magnitude of the numerator, divider and root terms
    assign pl     = macc_reg[MW-1:0];
    assign sprod  = mneg_reg ? $signed(MW'(-pl)) : $signed(pl);
    assign mnum   = mag(num_reg);
    assign rsh    = {drem_reg[RW-1:0], dnd_reg[RW-1]};
    assign lim    = neg_reg ? (RW'(1) << (SW - 1)) : ((RW'(1) << (SW - 1)) - RW'(1));
    assign qsat   = (dnd_reg > lim) ? lim : dnd_reg;
    assign rt     = rc_reg | (RB'(1) << rb_reg);
    assign rsq    = (2*RB)'(rt) * (2*RB)'(rt);
    assign dx_bad = dx_reg[MW-1] || (dx_reg == '0);
    assign dy_bad = (t1_reg - sprod) <= 0;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        dsel_next   = dsel_reg;
        n_next      = n_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxy_next    = sxy_reg;
        sxx_next    = sxx_reg;
        syy_next    = syy_reg;
        ovf_next    = ovf_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        macc_next   = macc_reg;
        mneg_next   = mneg_reg;
        p_next      = p_reg;
        t1_next     = t1_reg;
        num_next    = num_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        neg_next    = neg_reg;
        drem_next   = drem_reg;
        dnd_next    = dnd_reg;
        dsor_next   = dsor_reg;
        dcnt_next   = dcnt_reg;
        rc_next     = rc_reg;
        rb_next     = rb_reg;
        st_next     = st_reg;
        wslope_next = wslope_reg;
        wcorr_next  = wcorr_reg;
        pc_next     = pc_reg;
        ov_next     = ov_reg & ~result_ready;
        oslope_next = oslope_reg;
        ocorr_next  = ocorr_reg;
        ost_next    = ost_reg;
        opc_next    = opc_reg;

        case (state_reg)
            // take the next finished set
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    n_next   = in_n;
                    sx_next  = in_sx;
                    sy_next  = in_sy;
                    sxy_next = in_sxy;
                    sxx_next = in_sxx;
                    syy_next = in_syy;
                    ovf_next = in_ovf;
                    pc_next  = (32'(in_n) > 32'(rsc_pkg::PC_MAX)) ?
                               rsc_pkg::PC_W'(rsc_pkg::PC_MAX) : rsc_pkg::PC_W'(in_n);
                    op_next    = OP_N_SXY;
                    state_next = ST_LOAD;
                end
            end

            // start the shift-add multiplier
            ST_LOAD:
            begin
                ma_next    = (2*MW)'(opa);
                mb_next    = opb;
                mneg_next  = opneg;
                macc_next  = '0;
                state_next = ST_MUL;
            end

            // one multiplier bit per cycle, done once the shifted operand is empty
            ST_MUL:
            begin
                if (mb_reg != '0)
                begin
                    if (mb_reg[0])
                    begin
                        macc_next = macc_reg + ma_reg;
                    end
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg >> 1;
                end
                else
                begin
                    case (op_reg)
                        OP_N_SXY, OP_N_SXX, OP_N_SYY:
                        begin
                            t1_next    = sprod;
                            op_next    = op_reg + 3'd1;
                            state_next = ST_LOAD;
                        end
                        OP_SX_SY:
                        begin
                            num_next   = t1_reg - sprod;
                            op_next    = OP_N_SXX;
                            state_next = ST_LOAD;
                        end
                        OP_SX_SX:
                        begin
                            dx_next    = t1_reg - sprod;
                            op_next    = OP_N_SYY;
                            state_next = ST_LOAD;
                        end
                        OP_SY_SY:
                        begin
                            dy_next     = t1_reg - sprod;
                            neg_next    = num_reg[MW-1];
                            wslope_next = '0;
                            wcorr_next  = '0;
                            if (ovf_reg)
                            begin
                                st_next    = rsc_pkg::STATUS_OVERFLOW;
                                state_next = ST_DONE;
                            end
                            else if (dx_bad)
                            begin
                                st_next    = rsc_pkg::STATUS_X_CONST;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                st_next    = dy_bad ? rsc_pkg::STATUS_Y_CONST :
                                                      rsc_pkg::STATUS_OK;
                                drem_next  = '0;
                                dnd_next   = RW'({mnum, {rsc_pkg::SLOPE_FRAC{1'b0}}});
                                dsor_next  = RW'($unsigned(dx_reg));
                                dcnt_next  = RCW'(RW);
                                dsel_next  = 1'b0;
                                state_next = ST_DIV;
                            end
                        end
                        OP_DX_DY:
                        begin
                            p_next     = macc_reg;
                            op_next    = OP_M_M;
                            state_next = ST_LOAD;
                        end
                        OP_M_M:
                        begin
                            drem_next  = '0;
                            dnd_next   = {macc_reg, {CS{1'b0}}};
                            dsor_next  = RW'(p_reg);
                            dcnt_next  = RCW'(RW);
                            dsel_next  = 1'b1;
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    dcnt_next = dcnt_reg - RCW'(1);
                    dnd_next  = {dnd_reg[RW-2:0], 1'b0};
                    if (rsh >= {1'b0, dsor_reg})
                    begin
                        drem_next   = rsh - {1'b0, dsor_reg};
                        dnd_next[0] = 1'b1;
                    end
                    else
                    begin
                        drem_next = rsh;
                    end
                end
                else if (!dsel_reg)
                begin
                    wslope_next = neg_reg ? SW'(-qsat) : SW'(qsat);
                    if (st_reg == rsc_pkg::STATUS_Y_CONST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op_next    = OP_DX_DY;
                        state_next = ST_LOAD;
                    end
                end
                else if (|dnd_reg[RW-1:CS])
                begin
                    wcorr_next = neg_reg ? KW'(-rsc_pkg::CORR_MAX) : KW'(rsc_pkg::CORR_MAX);
                    state_next = ST_DONE;
                end
                else
                begin
                    rc_next    = '0;
                    rb_next    = 4'(RB - 1);
                    state_next = ST_ROOT;
                end
            end

            // square root of the scaled ratio, one bit per cycle
            ST_ROOT:
            begin
                if (rsq <= dnd_reg[CS-1:0])
                begin
                    rc_next = rt;
                end
                if (rb_reg == 4'd0)
                begin
                    wcorr_next = neg_reg ? KW'(-KW'(rc_next)) : KW'(rc_next);
                    state_next = ST_DONE;
                end
                else
                begin
                    rb_next = rb_reg - 4'd1;
                end
            end

            // hand over once the output register is free
            ST_DONE:
            begin
                if (!ov_reg || result_ready)
                begin
                    ov_next     = 1'b1;
                    oslope_next = wslope_reg;
                    ocorr_next  = wcorr_reg;
                    ost_next    = st_reg;
                    opc_next    = pc_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, working and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ov_reg     <= 1'b0;
            op_reg     <= OP_N_SXY;
            dsel_reg   <= 1'b0;
            n_reg      <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sxy_reg    <= '0;
            sxx_reg    <= '0;
            syy_reg    <= '0;
            ovf_reg    <= 1'b0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            macc_reg   <= '0;
            mneg_reg   <= 1'b0;
            p_reg      <= '0;
            t1_reg     <= '0;
            num_reg    <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            neg_reg    <= 1'b0;
            drem_reg   <= '0;
            dnd_reg    <= '0;
            dsor_reg   <= '0;
            dcnt_reg   <= '0;
            rc_reg     <= '0;
            rb_reg     <= '0;
            st_reg     <= rsc_pkg::STATUS_OK;
            wslope_reg <= '0;
            wcorr_reg  <= '0;
            pc_reg     <= '0;
            oslope_reg <= '0;
            ocorr_reg  <= '0;
            ost_reg    <= '0;
            opc_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            op_reg     <= op_next;
            dsel_reg   <= dsel_next;
            n_reg      <= n_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            sxy_reg    <= sxy_next;
            sxx_reg    <= sxx_next;
            syy_reg    <= syy_next;
            ovf_reg    <= ovf_next;
            ma_reg     <= ma_next;
            mb_reg     <= mb_next;
            macc_reg   <= macc_next;
            mneg_reg   <= mneg_next;
            p_reg      <= p_next;
            t1_reg     <= t1_next;
            num_reg    <= num_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            neg_reg    <= neg_next;
            drem_reg   <= drem_next;
            dnd_reg    <= dnd_next;
            dsor_reg   <= dsor_next;
            dcnt_reg   <= dcnt_next;
            rc_reg     <= rc_next;
            rb_reg     <= rb_next;
            st_reg     <= st_next;
            wslope_reg <= wslope_next;
            wcorr_reg  <= wcorr_next;
            pc_reg     <= pc_next;
            oslope_reg <= oslope_next;
            ocorr_reg  <= ocorr_next;
            ost_reg    <= ost_next;
            opc_reg    <= opc_next;
        end
    end

endmodule

// ----- src/regression_slope_and_correlation.sv -----
// channel   valid          ready          payload
// sample    sample_valid   sample_ready   sample_x, sample_y, last
// result    result_valid   result_ready   slope, correlation, status, pair_count
//
// pairs are summed at one per cycle while sample_ready is high; a pair marked last
// closes the set into a two-entry queue; each set then goes through the shared serial
// multiplier, divider and root unit (widths MW = 2*SAMPLE_BITS + 2*clog2(MAX_SAMPLES+1) + 2,
// RW = 2*MW + 30); multiplies end early on small operands
// sample_ready drops only while the queue holds two closed sets
// reset clears the sums, the queue and the output register; no clearing pass
module regression_slope_and_correlation #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [rsc_pkg::IN_W-1:0]     sample_x,
    input  logic signed [rsc_pkg::IN_W-1:0]     sample_y,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [rsc_pkg::SLOPE_W-1:0]  slope,
    output logic signed [rsc_pkg::CORR_W-1:0]   correlation,
    output logic [rsc_pkg::STATUS_W-1:0]        status,
    output logic [rsc_pkg::PC_W-1:0]            pair_count
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SXW = SAMPLE_BITS + CW;
    localparam int SPW = 2 * SAMPLE_BITS + CW;
    localparam int DW  = 1 + CW + 2 * SXW + 3 * SPW;

    logic          push_valid, push_ready;
    logic [DW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [DW-1:0] pop_data;

    // accumulation front
    rsc_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .SXW         (SXW),
        .SPW         (SPW),
        .DW          (DW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .last         (last),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    // closed sets waiting for the back end
    rsc_queue #(
        .W (DW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // slope and coefficient evaluation
    rsc_back #(
        .CW  (CW),
        .SXW (SXW),
        .SPW (SPW),
        .DW  (DW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .slope        (slope),
        .correlation  (correlation),
        .status       (status),
        .pair_count   (pair_count)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int MAX_PAIRS   = 4096;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int TAIL_CYCLES = 1000;
    localparam int HOLD_START  = 15000;
    localparam int HOLD_CYCLES = 7000;

    // directed rows: x, y, last, typed, slope, correlation, status, pair count
    localparam int DIR_ROWS = 22;
    localparam longint DIR_TAB [DIR_ROWS][8] = '{
        '{3, 4, 1, 1, 0, 0, rsc_pkg::STATUS_X_CONST, 1},
        '{5, 1, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{5, 2, 1, 1, 0, 0, rsc_pkg::STATUS_X_CONST, 2},
        '{1, 7, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{2, 7, 1, 1, 0, 0, rsc_pkg::STATUS_Y_CONST, 2},
        '{0, 0, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{1, 2, 1, 1, 131072, rsc_pkg::CORR_MAX, rsc_pkg::STATUS_OK, 2},
        '{0, 0, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{1, -2, 1, 1, -131072, -rsc_pkg::CORR_MAX, rsc_pkg::STATUS_OK, 2},
        '{-32768, -32768, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{32767, 32767, 1, 1, 65536, rsc_pkg::CORR_MAX, rsc_pkg::STATUS_OK, 2},
        '{-32768, 32767, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{32767, -32768, 1, 1, -65536, -rsc_pkg::CORR_MAX, rsc_pkg::STATUS_OK, 2},
        '{0, -32768, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{1, 32767, 1, 1, 64'sd4294901760, rsc_pkg::CORR_MAX, rsc_pkg::STATUS_OK, 2},
        '{-1, 5, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{3, -9, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{100, 40, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{-7, 2, 1, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{32767, -1, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{-32768, 0, 0, 0, 0, 0, rsc_pkg::STATUS_OK, 0},
        '{12, 12, 1, 0, 0, 0, rsc_pkg::STATUS_OK, 0}
    };

    typedef struct {
        logic signed [rsc_pkg::IN_W-1:0]    x;
        logic signed [rsc_pkg::IN_W-1:0]    y;
        logic                               last;
        logic                               typed;
        logic signed [rsc_pkg::SLOPE_W-1:0] slope;
        logic signed [rsc_pkg::CORR_W-1:0]  corr;
        rsc_pkg::status_t                   status;
        logic [rsc_pkg::PC_W-1:0]           pc;
        logic                               pause;
    } pair_req_t;

    typedef struct {
        logic signed [rsc_pkg::SLOPE_W-1:0] slope;
        logic signed [rsc_pkg::CORR_W-1:0]  corr;
        rsc_pkg::status_t                   status;
        logic [rsc_pkg::PC_W-1:0]           pc;
    } fit_t;

    logic clk = 1'b0;
    logic rst_n;
    logic sample_valid;
    logic sample_ready;
    logic signed [rsc_pkg::IN_W-1:0] sample_x;
    logic signed [rsc_pkg::IN_W-1:0] sample_y;
    logic last;
    logic result_valid;
    logic result_ready;
    logic signed [rsc_pkg::SLOPE_W-1:0] slope;
    logic signed [rsc_pkg::CORR_W-1:0] correlation;
    logic [rsc_pkg::STATUS_W-1:0] status;
    logic [rsc_pkg::PC_W-1:0] pair_count;

    pair_req_t pair_reqs[$];
    fit_t      pending_fits[$];
    int        accepted_pairs = 0;
    int        mismatches = 0;
    int        cyc = 0;

    // running sums of the open set
    int      set_count = 0;
    longint  sum_x = 0;
    longint  sum_y = 0;
    longint  sum_xy = 0;
    longint  sum_xx = 0;
    longint  sum_yy = 0;
    logic    set_overflow = 1'b0;

    regression_slope_and_correlation dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready),
        .sample_x(sample_x), .sample_y(sample_y), .last(last),
        .result_valid(result_valid), .result_ready(result_ready),
        .slope(slope), .correlation(correlation), .status(status),
        .pair_count(pair_count)
    );

    always #1 clk = ~clk;

    // exact fit of the closed set
    function automatic fit_t fit_of_set();
        fit_t f;
        logic signed [255:0] n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w;
        logic signed [255:0] num, dx, dy, mag, quo, lim, prod, rhs, lhs;
        logic neg;
        int c, t;
        n_w = 256'(set_count);
        sx_w = 256'(sum_x);
        sy_w = 256'(sum_y);
        sxy_w = 256'(sum_xy);
        sxx_w = 256'(sum_xx);
        syy_w = 256'(sum_yy);
        num = n_w * sxy_w - sx_w * sy_w;
        dx = n_w * sxx_w - sx_w * sx_w;
        dy = n_w * syy_w - sy_w * sy_w;
        f.slope = '0;
        f.corr = '0;
        if (set_overflow)
            f.status = rsc_pkg::STATUS_OVERFLOW;
        else if (dx <= 0)
            f.status = rsc_pkg::STATUS_X_CONST;
        else if (dy <= 0)
            f.status = rsc_pkg::STATUS_Y_CONST;
        else
            f.status = rsc_pkg::STATUS_OK;
        if (f.status == rsc_pkg::STATUS_OK || f.status == rsc_pkg::STATUS_Y_CONST)
        begin
            neg = num < 0;
            mag = neg ? -num : num;
            quo = (mag <<< rsc_pkg::SLOPE_FRAC) / dx;
            lim = neg ? (256'sd1 <<< 47) : ((256'sd1 <<< 47) - 256'sd1);
            if (quo > lim)
                quo = lim;
            f.slope = neg ? -quo[rsc_pkg::SLOPE_W-1:0] : quo[rsc_pkg::SLOPE_W-1:0];
            if (f.status == rsc_pkg::STATUS_OK)
            begin
                prod = dx * dy;
                rhs = (mag * mag) <<< rsc_pkg::CORR_SHIFT;
                c = 0;
                for (int b = rsc_pkg::ROOT_BITS; b >= 0; b--)
                begin
                    t = c | (1 << b);
                    lhs = 256'(t);
                    lhs = lhs * lhs * prod;
                    if (lhs <= rhs)
                        c = t;
                end
                if (c > rsc_pkg::CORR_MAX)
                    c = rsc_pkg::CORR_MAX;
                f.corr = neg ? -c[rsc_pkg::CORR_W-1:0] : c[rsc_pkg::CORR_W-1:0];
            end
        end
        f.pc = (set_count > rsc_pkg::PC_MAX) ? rsc_pkg::PC_W'(rsc_pkg::PC_MAX) :
                                               rsc_pkg::PC_W'(set_count);
        return f;
    endfunction

    function automatic void clear_set();
        set_count = 0;
        sum_x = 0;
        sum_y = 0;
        sum_xy = 0;
        sum_xx = 0;
        sum_yy = 0;
        set_overflow = 1'b0;
    endfunction

    function automatic void add_pair(int x, int y, bit is_last, bit typed,
                                     longint s, int cr, rsc_pkg::status_t st, int pc);
        pair_req_t r;
        r.x = rsc_pkg::IN_W'(x);
        r.y = rsc_pkg::IN_W'(y);
        r.last = is_last;
        r.typed = typed;
        r.slope = rsc_pkg::SLOPE_W'(s);
        r.corr = rsc_pkg::CORR_W'(cr);
        r.status = st;
        r.pc = rsc_pkg::PC_W'(pc);
        r.pause = 1'b0;
        pair_reqs.insert(pair_reqs.size(), r);
    endfunction

    function automatic void add_plain(int x, int y, bit is_last);
        add_pair(x, y, is_last, 1'b0, 0, 0, rsc_pkg::STATUS_OK, 0);
    endfunction

    // one random set of the given length and flavor
    function automatic void add_random_set(int len, int flavor);
        int x, y, k, off, cx, cy, amp;
        k = $urandom_range(7) - 3;
        off = $urandom_range(2000) - 1000;
        cx = $urandom_range(65535) - 32768;
        cy = $urandom_range(65535) - 32768;
        amp = (1 << $urandom_range(15)) - 1;
        for (int i = 0; i < len; i++)
        begin
            x = $urandom_range(65535) - 32768;
            y = $urandom_range(65535) - 32768;
            case (flavor)
                0: ;
                1:
                begin
                    x = $urandom_range(2 * amp) - amp;
                    y = k * x + off + $urandom_range(8) - 4;
                    if (y > 32767) y = 32767;
                    if (y < -32768) y = -32768;
                end
                2: x = cx;
                3: y = cy;
                4:
                begin
                    x = $urandom_range(1) ? 32767 : -32768;
                    y = $urandom_range(1) ? 32767 : -32768;
                end
                default:
                begin
                    x = $urandom_range(2 * amp) - amp;
                    y = $urandom_range(2 * amp) - amp;
                end
            endcase
            add_plain(x, y, i == len - 1);
        end
    endfunction

    // accept requests, predict, and check results
    always @(posedge clk)
    begin
        fit_t got;
        fit_t want;
        pair_req_t r;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got.slope = slope;
                got.corr = correlation;
                got.status = rsc_pkg::status_t'(status);
                got.pc = pair_count;
                if (pending_fits.size() == 0)
                begin
                    $error("result with no expected fit pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_fits.pop_front();
                    if (got.slope !== want.slope)
                    begin
                        $error("slope exp %0d got %0d", want.slope, got.slope);
                        mismatches++;
                    end
                    if (got.corr !== want.corr)
                    begin
                        $error("correlation exp %0d got %0d", want.corr, got.corr);
                        mismatches++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.pc !== want.pc)
                    begin
                        $error("pair_count exp %0d got %0d", want.pc, got.pc);
                        mismatches++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                r = pair_reqs[accepted_pairs];
                accepted_pairs++;
                if (set_count < MAX_PAIRS)
                begin
                    sum_x += longint'(sample_x);
                    sum_y += longint'(sample_y);
                    sum_xy += longint'(sample_x) * longint'(sample_y);
                    sum_xx += longint'(sample_x) * longint'(sample_x);
                    sum_yy += longint'(sample_y) * longint'(sample_y);
                    set_count++;
                end
                else
                    set_overflow = 1'b1;
                if (last)
                begin
                    want = fit_of_set();
                    if (r.typed)
                    begin
                        want.slope = r.slope;
                        want.corr = r.corr;
                        want.status = r.status;
                        want.pc = r.pc;
                    end
                    pending_fits.insert(pending_fits.size(), want);
                    clear_set();
                end
            end
        end
    end

    // receiver stalls, with one long hold-off
    always @(posedge clk)
    begin
        int mode;
        int hold_left;
        if (cyc % 300 == 0)
            mode = $urandom_range(3);
        if (cyc == HOLD_START)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (mode == 0)
            result_ready <= 1'b1;
        else if (mode == 1)
            result_ready <= 1'($urandom_range(1));
        else if (mode == 2)
            result_ready <= ($urandom_range(9) == 0);
        else
            result_ready <= ((cyc % 7) < 4);
    end

    // cycle limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int idx, gap_left, burst_left, len, flavor, tail;
        rst_n = 0;
        sample_valid = 0;
        sample_x = 0;
        sample_y = 0;
        last = 0;

        // directed sets: single pair, constant x, constant y, exact lines, extremes
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            add_pair(int'(DIR_TAB[i][0]), int'(DIR_TAB[i][1]), DIR_TAB[i][2] != 0,
                     DIR_TAB[i][3] != 0, DIR_TAB[i][4], int'(DIR_TAB[i][5]),
                     rsc_pkg::status_t'(DIR_TAB[i][6][1:0]), int'(DIR_TAB[i][7]));
        end

        // random sets, mostly short
        while (pair_reqs.size() < 1850)
        begin
            if ($urandom_range(19) == 0)
                len = $urandom_range(200, 40);
            else
                len = $urandom_range(12, 1);
            flavor = $urandom_range(5);
            if (len == 1 || $urandom_range(9) == 0)
                add_random_set(len, 0);
            else
                add_random_set(len, flavor);
        end
        pair_reqs[22].pause = 1'b1;
        pair_reqs[900].pause = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        gap_left = 0;
        burst_left = $urandom_range(20, 1);
        while (idx < pair_reqs.size())
        begin
            if (pair_reqs[idx].pause)
            begin
                // sender waits until every fit is back
                pair_reqs[idx].pause = 1'b0;
                sample_valid <= 1'b0;
                @(posedge clk);
                while (pending_fits.size() != 0)
                    @(posedge clk);
            end
            else if (gap_left > 0)
            begin
                sample_valid <= 1'b0;
                gap_left--;
                @(posedge clk);
            end
            else
            begin
                sample_valid <= 1'b1;
                sample_x <= pair_reqs[idx].x;
                sample_y <= pair_reqs[idx].y;
                last <= pair_reqs[idx].last;
                @(posedge clk);
                while (!sample_ready)
                    @(posedge clk);
                idx++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end
            end
        end
        sample_valid <= 1'b0;

        while (pending_fits.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < TAIL_CYCLES)
        begin
            @(posedge clk);
            tail++;
        end
        if (mismatches == 0 && pending_fits.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rsc_pkg.sv
src/rsc_front.sv
src/rsc_queue.sv
src/rsc_back.sv
src/regression_slope_and_correlation.sv
bench/tb.sv
